>>> hdl/assert_macros.svh
// assertion macros shared by the texel unpack rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, disabled while reset is asserted
`define TFU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tfu assertion failed");

// clocked check that also holds during reset
`define TFU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tfu assertion failed");

`else

`define TFU_ASSERT(lbl, prop)
`define TFU_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> hdl/tfu_pkg.sv
// shared types and constants of the texel format unpacker
package tfu_pkg;

  localparam int unsigned OutBits   = 16;
  localparam int unsigned CompBits  = 32;
  localparam int unsigned NumComps  = 4;
  localparam int unsigned UsedBits  = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 4;
  localparam int unsigned InDataW   = NumComps * CompBits;
  localparam int unsigned OutFieldW = 4 * OutBits + UsedBits;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam logic [OutBits-1:0] FullScale = {OutBits{1'b1}};

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegPixelFormat  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegComponentType = 1'b1;

  localparam logic [UsedBits-1:0] Used1 = 3'd1;
  localparam logic [UsedBits-1:0] Used2 = 3'd2;
  localparam logic [UsedBits-1:0] Used3 = 3'd3;
  localparam logic [UsedBits-1:0] Used4 = 3'd4;

  typedef enum logic [3:0] {
    PF_RED       = 4'd0,
    PF_GREEN     = 4'd1,
    PF_BLUE      = 4'd2,
    PF_ALPHA     = 4'd3,
    PF_RGB       = 4'd4,
    PF_BGR       = 4'd5,
    PF_RGBA      = 4'd6,
    PF_BGRA      = 4'd7,
    PF_INTENSITY = 4'd8,
    PF_LUMINANCE = 4'd9,
    PF_LUM_ALPHA = 4'd10
  } pixel_format_e;

  typedef enum logic [2:0] {
    CT_U8  = 3'd0,
    CT_S8  = 3'd1,
    CT_U16 = 3'd2,
    CT_S16 = 3'd3,
    CT_U32 = 3'd4,
    CT_S32 = 3'd5,
    CT_F32 = 3'd6
  } comp_type_e;

  typedef logic [NumComps-1:0][OutBits-1:0] chan_vec_t;

  typedef struct packed {
    logic [UsedBits-1:0] used;
    logic [OutBits-1:0]  alpha;
    logic [OutBits-1:0]  blue;
    logic [OutBits-1:0]  green;
    logic [OutBits-1:0]  red;
  } pixel_t;

endpackage

>>> hdl/tfu_convert.sv
// one raw component normalized to a 16-bit unorm value
module tfu_convert (
  input  tfu_pkg::comp_type_e          comp_type_i,
  input  logic [tfu_pkg::CompBits-1:0] raw_i,
  output logic [tfu_pkg::OutBits-1:0]  chan_o
);

  // 32-bit integer path: (v * 65535 + 2^31) / (2^32 - 1)
  logic [31:0] v32;
  logic [47:0] num48;
  logic [15:0] hi16;
  logic [32:0] fold33;
  logic        fold_carry;
  logic [15:0] int32_res;

  // float path
  logic        f_sign;
  logic [7:0]  f_exp;
  logic [22:0] f_man;
  logic [23:0] f_sig;
  logic [39:0] f_prod;
  logic [16:0] f_top;
  logic [7:0]  f_shift8;
  logic [16:0] f_shifted;
  logic [16:0] f_round;
  logic [15:0] float_res;

  logic [7:0]  s8;
  logic [15:0] s16;

  always_comb begin
    v32 = (comp_type_i == tfu_pkg::CT_S32) ? (raw_i ^ 32'h8000_0000) : raw_i;
    num48 = {v32, 16'h0000} - {16'h0000, v32} + 48'h0000_8000_0000;
    hi16 = num48[47:32];
    // x = hi*(2^32-1) + (hi + lo), and hi + lo stays below twice the divisor
    fold33 = {1'b0, num48[31:0]} + {17'h0_0000, hi16};
    fold_carry = (fold33 >= 33'h0_FFFF_FFFF);
    int32_res = hi16 + {15'h0000, fold_carry};
  end

  always_comb begin
    f_sign = raw_i[31];
    f_exp = raw_i[30:23];
    f_man = raw_i[22:0];
    f_sig = {1'b1, f_man};
    f_prod = {f_sig, 16'h0000} - {16'h0000, f_sig};
    f_top = f_prod[39:23];
    // only exponents 109..126 reach this path, so the shift is 0..17
    f_shift8 = 8'd126 - f_exp;
    f_shifted = f_top >> f_shift8[4:0];
    f_round = f_shifted + 17'd1;
    if (f_exp == 8'hFF && f_man != 23'h00_0000) begin
      float_res = '0;
    end else if (f_sign) begin
      float_res = '0;
    end else if (f_exp >= 8'd127) begin
      float_res = tfu_pkg::FullScale;
    end else if (f_exp <= 8'd108) begin
      float_res = '0;
    end else begin
      float_res = f_round[16:1];
    end
  end

  always_comb begin
    s8  = raw_i[7:0] ^ 8'h80;
    s16 = raw_i[15:0] ^ 16'h8000;
    case (comp_type_i)
      tfu_pkg::CT_S8: begin
        chan_o = {s8, s8};
      end
      tfu_pkg::CT_U16: begin
        chan_o = raw_i[15:0];
      end
      tfu_pkg::CT_S16: begin
        chan_o = s16;
      end
      tfu_pkg::CT_U32, tfu_pkg::CT_S32: begin
        chan_o = int32_res;
      end
      tfu_pkg::CT_F32: begin
        chan_o = float_res;
      end
      default: begin
        // 8 bit times 65535/255 is an exact byte replication
        chan_o = {raw_i[7:0], raw_i[7:0]};
      end
    endcase
  end

endmodule

>>> hdl/tfu_pixel_map.sv
// maps converted components onto rgba by pixel format
module tfu_pixel_map (
  input  tfu_pkg::pixel_format_e pixel_format_i,
  input  tfu_pkg::chan_vec_t     chan_i,
  output tfu_pkg::pixel_t        pixel_o
);

  always_comb begin
    pixel_o.red   = '0;
    pixel_o.green = '0;
    pixel_o.blue  = '0;
    pixel_o.alpha = tfu_pkg::FullScale;
    pixel_o.used  = tfu_pkg::Used1;
    case (pixel_format_i)
      tfu_pkg::PF_RED: begin
        pixel_o.red = chan_i[0];
      end
      tfu_pkg::PF_GREEN: begin
        pixel_o.green = chan_i[0];
      end
      tfu_pkg::PF_BLUE: begin
        pixel_o.blue = chan_i[0];
      end
      tfu_pkg::PF_ALPHA: begin
        pixel_o.alpha = chan_i[0];
      end
      tfu_pkg::PF_RGB: begin
        pixel_o.red   = chan_i[0];
        pixel_o.green = chan_i[1];
        pixel_o.blue  = chan_i[2];
        pixel_o.used  = tfu_pkg::Used3;
      end
      tfu_pkg::PF_BGR: begin
        pixel_o.blue  = chan_i[0];
        pixel_o.green = chan_i[1];
        pixel_o.red   = chan_i[2];
        pixel_o.used  = tfu_pkg::Used3;
      end
      tfu_pkg::PF_BGRA: begin
        pixel_o.blue  = chan_i[0];
        pixel_o.green = chan_i[1];
        pixel_o.red   = chan_i[2];
        pixel_o.alpha = chan_i[3];
        pixel_o.used  = tfu_pkg::Used4;
      end
      tfu_pkg::PF_INTENSITY: begin
        pixel_o.red   = chan_i[0];
        pixel_o.green = chan_i[0];
        pixel_o.blue  = chan_i[0];
        pixel_o.alpha = chan_i[0];
      end
      tfu_pkg::PF_LUMINANCE: begin
        pixel_o.red   = chan_i[0];
        pixel_o.green = chan_i[0];
        pixel_o.blue  = chan_i[0];
      end
      tfu_pkg::PF_LUM_ALPHA: begin
        pixel_o.red   = chan_i[0];
        pixel_o.green = chan_i[0];
        pixel_o.blue  = chan_i[0];
        pixel_o.alpha = chan_i[1];
        pixel_o.used  = tfu_pkg::Used2;
      end
      default: begin
        // rgba and unused codes
        pixel_o.red   = chan_i[0];
        pixel_o.green = chan_i[1];
        pixel_o.blue  = chan_i[2];
        pixel_o.alpha = chan_i[3];
        pixel_o.used  = tfu_pkg::Used4;
      end
    endcase
  end

endmodule

>>> hdl/texel_format_unpack_top.sv
// texel format unpacker: raw pixel components in, unorm16 rgba out
//
// usage: send one source pixel per transfer on the s_axis channel, four raw
// 32-bit components in memory order (comp0 in the lowest bits). each
// transfer on m_axis carries the rgba pixel as 16-bit unorm channels plus
// the number of components the pixel format consumed.
// the cfg channel writes pixel_format (index 0) and component_type
// (index 1); it is always ready and should only be used while no pixel is
// in flight.
// an input transfer is held in the input register and then in the result
// register, with the conversion and channel mapping between them.
// throughput: one pixel per cycle while the receiver takes results, set by
// the single conversion pass.
// when the receiver stalls, the result register holds and the input
// register still takes one more pixel, so up to two pixels are buffered.
// reset clears both pipeline stages and sets the format to rgba and the
// component type to unsigned 8 bit.
`include "assert_macros.svh"

module texel_format_unpack_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tfu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tfu_pkg::CfgDataW-1:0]  cfg_data_i,
  // input pixel stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tfu_pkg::InDataW-1:0]   s_axis_tdata_i,  // comp0, comp1, comp2, comp3
  // output pixel stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [tfu_pkg::OutDataW-1:0]  m_axis_tdata_o   // red, green, blue, alpha,
                                                         // components_used, zero pad
);

  tfu_pkg::pixel_format_e pixel_format_q;
  tfu_pkg::comp_type_e    comp_type_q;

  logic                                         in_valid_q;
  logic [tfu_pkg::NumComps-1:0][tfu_pkg::CompBits-1:0] comp_q;
  logic                                         out_valid_q;
  tfu_pkg::pixel_t                              pixel_q;

  tfu_pkg::chan_vec_t chan;
  tfu_pkg::pixel_t    pixel_d;
  logic               out_free;
  logic               in_free;
  logic               in_xfer;
  logic               used_ok;
  logic               three_comp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= tfu_pkg::PF_RGBA;
      comp_type_q    <= tfu_pkg::CT_U8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tfu_pkg::RegPixelFormat) begin
        pixel_format_q <= tfu_pkg::pixel_format_e'(cfg_data_i);
      end else begin
        comp_type_q <= tfu_pkg::comp_type_e'(cfg_data_i[2:0]);
      end
    end
  end

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_free         = !in_valid_q || out_free;
  assign s_axis_tready_o = in_free;
  assign in_xfer         = s_axis_tvalid_i && in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      comp_q <= s_axis_tdata_i;
    end
  end

  for (genvar i = 0; i < tfu_pkg::NumComps; i++) begin : g_conv
    tfu_convert u_convert (
      .comp_type_i (comp_type_q),
      .raw_i       (comp_q[i]),
      .chan_o      (chan[i])
    );
  end

  tfu_pixel_map u_pixel_map (
    .pixel_format_i (pixel_format_q),
    .chan_i         (chan),
    .pixel_o        (pixel_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_valid_q) begin
      pixel_q <= pixel_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(tfu_pkg::OutDataW - tfu_pkg::OutFieldW){1'b0}}, pixel_q};

  assign used_ok    = pixel_q.used inside {[tfu_pkg::Used1:tfu_pkg::Used4]};
  assign three_comp = out_valid_q && (pixel_q.used == tfu_pkg::Used3);

  `TFU_ASSERT(a_in_load, in_xfer |=> in_valid_q)
  `TFU_ASSERT(a_out_load, (in_valid_q && out_free) |=> out_valid_q)
  `TFU_ASSERT_ALWAYS(a_used_range, out_valid_q |-> used_ok)
  `TFU_ASSERT(a_rgb_opaque, three_comp |-> (pixel_q.alpha == tfu_pkg::FullScale))

endmodule

>>> bench/tfu_checker.sv
// pixel predictor and scoreboard for the texel format unpacker bench
module tfu_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [tfu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tfu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [tfu_pkg::InDataW-1:0]  s_tdata_i,   // comp0, comp1, comp2, comp3
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [tfu_pkg::OutDataW-1:0] m_tdata_i,   // red, green, blue, alpha, used, zero pad
  output int unsigned                  pending_o,
  output int unsigned                  mismatches_o,
  output int unsigned                  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [3:0]      pix_fmt;
  logic [2:0]      comp_type;
  tfu_pkg::pixel_t rgba_expected_q[$];

  function automatic bit [63:0] scale_uint(bit [63:0] v, int unsigned nbits);
    bit [63:0] d;
    d = (64'd1 << nbits) - 64'd1;
    return (v * 64'(tfu_pkg::FullScale) + (d >> 1) + 64'd1) / d;
  endfunction

  function automatic bit [63:0] float_to_unorm(logic [tfu_pkg::CompBits-1:0] f);
    logic [7:0]  ex;
    logic [22:0] man;
    bit [63:0]   sig;
    bit [63:0]   prod;
    int unsigned sh;
    ex  = f[30:23];
    man = f[22:0];
    // nan and anything with the sign bit set go to zero
    if (f[31] || (ex == 8'hFF && man != '0)) return '0;
    if (ex >= 8'd127) return 64'(tfu_pkg::FullScale);
    if (ex == 8'd0) begin
      sig = 64'(man);
      sh  = 149;
    end else begin
      sig = 64'({1'b1, man});
      sh  = 150 - int'(ex);
    end
    if (sh >= 60) return '0;
    prod = sig * 64'(tfu_pkg::FullScale);
    return (prod + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [tfu_pkg::OutBits-1:0] to_unorm(
    logic [tfu_pkg::CompBits-1:0] raw, logic [2:0] ct);
    bit [63:0] v;
    case (ct)
      tfu_pkg::CT_S8:  v = scale_uint(64'(raw[7:0] ^ 8'h80), 8);
      tfu_pkg::CT_U16: v = scale_uint(64'(raw[15:0]), 16);
      tfu_pkg::CT_S16: v = scale_uint(64'(raw[15:0] ^ 16'h8000), 16);
      tfu_pkg::CT_U32: v = scale_uint(64'(raw), 32);
      tfu_pkg::CT_S32: v = scale_uint(64'(raw ^ 32'h8000_0000), 32);
      tfu_pkg::CT_F32: v = float_to_unorm(raw);
      default:         v = scale_uint(64'(raw[7:0]), 8);
    endcase
    return v[tfu_pkg::OutBits-1:0];
  endfunction

  function automatic tfu_pkg::pixel_t predict_rgba(logic [tfu_pkg::InDataW-1:0] px);
    tfu_pkg::chan_vec_t c;
    tfu_pkg::pixel_t    r;
    for (int k = 0; k < tfu_pkg::NumComps; k++) begin
      c[k] = to_unorm(px[k*tfu_pkg::CompBits +: tfu_pkg::CompBits], comp_type);
    end
    r.red   = '0;
    r.green = '0;
    r.blue  = '0;
    r.alpha = tfu_pkg::FullScale;
    r.used  = tfu_pkg::Used1;
    case (pix_fmt)
      tfu_pkg::PF_RED:   r.red = c[0];
      tfu_pkg::PF_GREEN: r.green = c[0];
      tfu_pkg::PF_BLUE:  r.blue = c[0];
      tfu_pkg::PF_ALPHA: r.alpha = c[0];
      tfu_pkg::PF_RGB: begin
        r.red = c[0]; r.green = c[1]; r.blue = c[2]; r.used = tfu_pkg::Used3;
      end
      // bgr orders take blue first in memory
      tfu_pkg::PF_BGR: begin
        r.blue = c[0]; r.green = c[1]; r.red = c[2]; r.used = tfu_pkg::Used3;
      end
      tfu_pkg::PF_BGRA: begin
        r.blue = c[0]; r.green = c[1]; r.red = c[2]; r.alpha = c[3];
        r.used = tfu_pkg::Used4;
      end
      tfu_pkg::PF_INTENSITY: begin
        r.red = c[0]; r.green = c[0]; r.blue = c[0]; r.alpha = c[0];
      end
      tfu_pkg::PF_LUMINANCE: begin
        r.red = c[0]; r.green = c[0]; r.blue = c[0];
      end
      tfu_pkg::PF_LUM_ALPHA: begin
        r.red = c[0]; r.green = c[0]; r.blue = c[0]; r.alpha = c[1];
        r.used = tfu_pkg::Used2;
      end
      // rgba and the unused codes
      default: begin
        r.red = c[0]; r.green = c[1]; r.blue = c[2]; r.alpha = c[3];
        r.used = tfu_pkg::Used4;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tfu_pkg::pixel_t                                got;
    tfu_pkg::pixel_t                                want;
    logic [tfu_pkg::OutDataW-tfu_pkg::OutFieldW-1:0] pad;
    if (!rst_ni) begin
      pix_fmt      = tfu_pkg::PF_RGBA;
      comp_type    = tfu_pkg::CT_U8;
      rgba_expected_q.delete();
      pending_o    = 0;
      mismatches_o = 0;
      checked_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[tfu_pkg::OutFieldW-1:0];
        pad = m_tdata_i[tfu_pkg::OutDataW-1:tfu_pkg::OutFieldW];
        if (rgba_expected_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result transfer with no pixel pending: r %h g %h b %h a %h used %0d",
                     $time, got.red, got.green, got.blue, got.alpha, got.used);
          mismatches_o++;
        end else begin
          want = rgba_expected_q.pop_front();
          if (got.red != want.red || got.green != want.green || got.blue != want.blue ||
              got.alpha != want.alpha || got.used != want.used || pad != '0) begin
            if (mismatches_o < 10) begin
              $display("%0t: pixel %0d mismatch (fmt %0d type %0d)", $time, checked_o,
                       pix_fmt, comp_type);
              $display("  expected r %h g %h b %h a %h used %0d", want.red, want.green,
                       want.blue, want.alpha, want.used);
              $display("  actual   r %h g %h b %h a %h used %0d pad %h", got.red, got.green,
                       got.blue, got.alpha, got.used, pad);
            end
            mismatches_o++;
          end
          checked_o++;
        end
      end
      if (s_tvalid_i && s_tready_i) rgba_expected_q.push_back(predict_rgba(s_tdata_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == tfu_pkg::RegPixelFormat) pix_fmt = cfg_data_i;
        else comp_type = cfg_data_i[2:0];
      end
      pending_o = rgba_expected_q.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// stimulus, clock, reset and verdict for the texel format unpacker bench
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumPhases     = 32;
  localparam int unsigned PhaseItems    = 60;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 3000;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_valid_i     = 1'b0;
  logic                         cfg_ready_o;
  logic [tfu_pkg::CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [tfu_pkg::CfgDataW-1:0] cfg_data_i      = '0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [tfu_pkg::InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [tfu_pkg::OutDataW-1:0] m_axis_tdata_o;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned pixels_sent  = 0;
  int unsigned cfg_writes   = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;
  bit          press_go     = 1'b0;

  always #1 clk_i = ~clk_i;

  texel_format_unpack_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  tfu_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_i  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .m_tvalid_i  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_i   (m_axis_tdata_o),
    .pending_o   (pending),
    .mismatches_o(mismatches),
    .checked_o   (checked)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [tfu_pkg::CompBits-1:0] rand_comp(logic [2:0] ct);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (ct == tfu_pkg::CT_F32) begin
      if (pick < 55) return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
      if (pick < 63) return {1'b0, 8'h00, 23'($urandom)};
      if (pick < 73) return {1'b1, 31'($urandom)};
      if (pick < 88) begin
        case ($urandom_range(0, 9))
          0:       return 32'h3F80_0000;  // one
          1:       return 32'h7F80_0000;  // +inf
          2:       return 32'h7FC0_0000;  // quiet nan
          3:       return 32'hFF80_0000;  // -inf
          4:       return 32'h8000_0000;  // -0.0
          5:       return 32'h7F7F_FFFF;  // largest finite
          6:       return 32'h0000_0001;  // smallest denormal
          7:       return 32'h3F7F_FFFF;  // just under one
          8:       return 32'h3780_0000;  // 2^-16, just under one lsb of unorm16
          default: return 32'h0000_0000;
        endcase
      end
      return $urandom;
    end
    if (pick < 15) begin
      case ($urandom_range(0, 7))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        3:       return 32'h7FFF_FFFF;
        4:       return 32'h0000_8000;
        5:       return 32'h0000_7FFF;
        6:       return 32'h0000_0080;
        default: return 32'h0000_007F;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_pixel(logic [tfu_pkg::InDataW-1:0] px);
    int unsigned gap;
    gap = (tx_calm || $urandom_range(0, 99) < 50) ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pixels_sent++;
  endtask

  task automatic cfg_write(logic [tfu_pkg::CfgIdxW-1:0] idx,
                           logic [tfu_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
  endtask

  // registers change only once every pixel in flight has come out
  task automatic set_config(logic [3:0] fmt, logic [2:0] ct);
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    cfg_write(tfu_pkg::RegPixelFormat, fmt);
    cfg_write(tfu_pkg::RegComponentType, {1'($urandom), ct});
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    bit          held;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (press_go && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!rx_calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: no transfer for %0d cycles, %0d pixels pending", quiet_cycles,
                 pending);
        $display("[texel_format_unpack_top] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] lo_mark;
    logic [3:0]  fmt;
    logic [2:0]  ct;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting is rgba with u8 components
    send_pixel({32'h1234_567F, 32'hABCD_EF80, 32'h0000_00FF, 32'hFFFF_FF00});

    // each component type against its zero, full and sign-flip points
    for (int t = 0; t < 8; t++) begin
      set_config(tfu_pkg::PF_RGBA, 3'(t));
      case (3'(t))
        tfu_pkg::CT_S8:  lo_mark = 32'h0000_0080;
        tfu_pkg::CT_S16: lo_mark = 32'h0000_8000;
        default:         lo_mark = 32'h8000_0000;
      endcase
      send_pixel({lo_mark - 32'd1, lo_mark, 32'hFFFF_FFFF, 32'h0000_0000});
    end
    // float saturation, infinity, denormal and rounding near zero
    set_config(tfu_pkg::PF_RGBA, tfu_pkg::CT_F32);
    send_pixel({32'h3780_0000, 32'h0000_0001, 32'h7F80_0000, 32'h3F80_0000});

    // every format code, the unused ones too
    for (int f = 0; f < 16; f++) begin
      set_config(4'(f), tfu_pkg::CT_U16);
      send_pixel({32'hA5A5_DEF0, 32'h5A5A_9ABC, 32'hFFFF_5678, 32'h0000_1234});
    end

    for (int p = 0; p < NumPhases; p++) begin
      fmt = (p < 16) ? 4'(p) : 4'($urandom_range(0, 15));
      ct  = (p < 16) ? 3'(p % 8) : 3'($urandom_range(0, 7));
      set_config(fmt, ct);
      // some phases run with no idling; one keeps the input full during a long output hold
      tx_calm = (p % 5 == 4) || (p == 6);
      rx_calm = (p % 5 == 4);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 6 && i == 5) press_go <= 1'b1;
        send_pixel({rand_comp(ct), rand_comp(ct), rand_comp(ct), rand_comp(ct)});
      end
    end
    s_axis_tvalid_i <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);

    $display("run covered %0d pixels, %0d compared, over %0d register writes", pixels_sent,
             checked, cfg_writes);
    $display("all format and type codes, float specials, signed extremes, a %0d-cycle hold",
             HoldCycles);
    if (mismatches == 0) begin
      $display("[texel_format_unpack_top] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[texel_format_unpack_top] ERROR");
    end
    $finish;
  end

endmodule
